// ===== rtl/core/debounced_wheel_encoder_heading_top_assert.svh =====
// Assertion macros for the wheel encoder block. Each macro expects signals
// named clock and reset in the scope where it is used.
`ifndef DEBOUNCED_WHEEL_ENCODER_HEADING_TOP_ASSERT_SVH
`define DEBOUNCED_WHEEL_ENCODER_HEADING_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWEH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DWEH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dweh_pkg.sv =====
`default_nettype none

package dweh_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TIMER_WIDTH_DEFAULT = 8;

   localparam int CMD_WIDTH       = 2;
   localparam int SPEED_WIDTH     = 8;
   localparam int RSP_COUNT_WIDTH = 32;
   localparam int HEADING_WIDTH   = 8;
   localparam int DUTY_WIDTH      = 8;
   localparam int LOCKOUT_WIDTH   = 8;
   localparam int SCALE_WIDTH     = 18;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = SCALE_WIDTH;

   localparam logic [LOCKOUT_WIDTH-1:0] LOCKOUT_RESET = 8'd5;
   // About 1.515 in unsigned Q16.
   localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET   = 18'd99287;

   localparam int FRAC_BITS  = 16;
   localparam int ROUND_HALF = 32768;
   localparam logic [HEADING_WIDTH-1:0] FOLD_MODULUS = 8'd255;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_LEFT  = 2'd1,
      CMD_RIGHT = 2'd2,
      CMD_SPEED = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOCKOUT = 1'd0,
      CSR_SCALE   = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic                  reverse;
      logic [DUTY_WIDTH-1:0] duty;
   } drive_type;

   // Response fields that are known as soon as the request has updated the state.
   typedef struct packed {
      logic [RSP_COUNT_WIDTH-1:0] left_count;
      logic [RSP_COUNT_WIDTH-1:0] right_count;
      drive_type                  left_drive;
      drive_type                  right_drive;
      logic                       left_step;
      logic                       right_step;
   } rsp_base_type;

   // Negative speeds give 255 + 2*s, which is 2*s - 1 in eight bits.
   function automatic drive_type drive_of(input logic [SPEED_WIDTH-1:0] speed);
      drive_type result;
      result.reverse = speed[SPEED_WIDTH-1];
      if (speed[SPEED_WIDTH-1]) begin
         result.duty = DUTY_WIDTH'({speed[SPEED_WIDTH-2:0], 1'b0} + {DUTY_WIDTH{1'b1}});
      end else begin
         result.duty = {speed[SPEED_WIDTH-2:0], 1'b0};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dweh_req_if.sv =====
`default_nettype none

interface dweh_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [dweh_pkg::CMD_WIDTH-1:0]        command;
   logic signed [dweh_pkg::SPEED_WIDTH-1:0] left_speed;
   logic signed [dweh_pkg::SPEED_WIDTH-1:0] right_speed;

   modport source (output valid, command, left_speed, right_speed, input ready);
   modport sink (input valid, command, left_speed, right_speed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dweh_rsp_if.sv =====
`default_nettype none

interface dweh_rsp_if;
   logic                                         valid;
   logic                                         ready;
   logic signed [dweh_pkg::RSP_COUNT_WIDTH-1:0]  left_count;
   logic signed [dweh_pkg::RSP_COUNT_WIDTH-1:0]  right_count;
   logic [dweh_pkg::HEADING_WIDTH-1:0]           heading;
   logic [dweh_pkg::DUTY_WIDTH-1:0]              left_duty;
   logic                                         left_reverse;
   logic [dweh_pkg::DUTY_WIDTH-1:0]              right_duty;
   logic                                         right_reverse;
   logic                                         left_step;
   logic                                         right_step;

   modport source (output valid, left_count, right_count, heading, left_duty,
                   left_reverse, right_duty, right_reverse, left_step, right_step,
                   input ready);
   modport sink (input valid, left_count, right_count, heading, left_duty,
                 left_reverse, right_duty, right_reverse, left_step, right_step,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dweh_csr_if.sv =====
`default_nettype none

interface dweh_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [dweh_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [dweh_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/debounced_wheel_encoder_heading_top.sv =====
// Six registers carry a response from the edge that accepts its request:
// the state snapshot, four heading stages (sign and magnitude, two
// half-width multiplies, a wide add, a byte-sum fold) and the output
// register. Throughput: one request per cycle while the output is not stalled.
// Reset (synchronous, active high) clears counts and directions, saturates
// both timers, zeroes the drives, loads lockout 5 and scale 99287, and
// empties the pipeline. Configuration writes are taken every cycle.
`default_nettype none

`include "debounced_wheel_encoder_heading_top_assert.svh"

module debounced_wheel_encoder_heading_top #(
   parameter int COUNT_WIDTH = dweh_pkg::COUNT_WIDTH_DEFAULT,
   parameter int TIMER_WIDTH = dweh_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   dweh_req_if.sink    req_ch,
   dweh_rsp_if.source  rsp_ch,
   dweh_csr_if.sink    csr_ch
);

   // The count magnitude is split into two halves, each small enough for one
   // multiplier with the 18-bit scale.
   localparam int HALF_WIDTH = (COUNT_WIDTH + 1) / 2;
   localparam int HIGH_WIDTH = COUNT_WIDTH - HALF_WIDTH;
   localparam int PROD_LO_WIDTH = HALF_WIDTH + dweh_pkg::SCALE_WIDTH;
   localparam int PROD_HI_WIDTH = HIGH_WIDTH + dweh_pkg::SCALE_WIDTH;
   localparam int PROD_WIDTH = COUNT_WIDTH + dweh_pkg::SCALE_WIDTH + 1;
   localparam int Q_WIDTH = PROD_WIDTH - dweh_pkg::FRAC_BITS;
   localparam int Q_BYTES = (Q_WIDTH + 7) / 8;
   localparam int SUM_WIDTH = $clog2(Q_BYTES * 255 + 1);
   localparam int CMP_WIDTH =
      (TIMER_WIDTH > dweh_pkg::LOCKOUT_WIDTH) ? TIMER_WIDTH : dweh_pkg::LOCKOUT_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   // ------------------------------------------------------------------
   // Configuration registers. The port never pushes back.
   // ------------------------------------------------------------------
   logic [dweh_pkg::LOCKOUT_WIDTH-1:0] lockout_ff;
   logic [dweh_pkg::SCALE_WIDTH-1:0]   scale_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= dweh_pkg::LOCKOUT_RESET;
         scale_ff   <= dweh_pkg::SCALE_RESET;
      end else if (csr_ch.valid) begin
         case (dweh_pkg::csr_index_type'(csr_ch.index))
            dweh_pkg::CSR_LOCKOUT: begin
               lockout_ff <= csr_ch.data[dweh_pkg::LOCKOUT_WIDTH-1:0];
            end
            dweh_pkg::CSR_SCALE: begin
               scale_ff <= csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it loads, so bubbles collapse and a request is taken
   // even while a finished response waits at the output.
   // ------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic en1, en2, en3, en4, en5, en_out;
   logic accept;

   assign en_out = !out_v_ff || rsp_ch.ready;
   assign en5    = !s5_v_ff || en_out;
   assign en4    = !s4_v_ff || en5;
   assign en3    = !s3_v_ff || en4;
   assign en2    = !s2_v_ff || en3;
   assign en1    = !s1_v_ff || en2;

   assign req_ch.ready = en1;
   assign accept       = req_ch.valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= accept;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en4) begin
            s4_v_ff <= s3_v_ff;
         end
         if (en5) begin
            s5_v_ff <= s4_v_ff;
         end
         if (en_out) begin
            out_v_ff <= s5_v_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Wheel state. Each accepted request updates it, and the updated values
   // are snapshotted into the first pipeline stage.
   // ------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] left_pos_ff, left_pos_in;
   logic [COUNT_WIDTH-1:0] right_pos_ff, right_pos_in;
   logic [TIMER_WIDTH-1:0] left_elapsed_ff, left_elapsed_in;
   logic [TIMER_WIDTH-1:0] right_elapsed_ff, right_elapsed_in;
   logic                   left_ahead_ff, left_ahead_in;
   logic                   right_ahead_ff, right_ahead_in;
   dweh_pkg::drive_type    left_drive_ff, left_drive_in;
   dweh_pkg::drive_type    right_drive_ff, right_drive_in;

   logic left_open, right_open;
   logic left_step_now, right_step_now;
   dweh_pkg::cmd_type cmd;

   assign cmd = dweh_pkg::cmd_type'(req_ch.command);

   // An edge counts only once the wheel's timer has run past the lockout.
   assign left_open  = CMP_WIDTH'(left_elapsed_ff) > CMP_WIDTH'(lockout_ff);
   assign right_open = CMP_WIDTH'(right_elapsed_ff) > CMP_WIDTH'(lockout_ff);

   always_comb begin
      left_pos_in      = left_pos_ff;
      right_pos_in     = right_pos_ff;
      left_elapsed_in  = left_elapsed_ff;
      right_elapsed_in = right_elapsed_ff;
      left_ahead_in    = left_ahead_ff;
      right_ahead_in   = right_ahead_ff;
      left_drive_in    = left_drive_ff;
      right_drive_in   = right_drive_ff;
      left_step_now    = 1'b0;
      right_step_now   = 1'b0;
      if (accept) begin
         case (cmd)
            dweh_pkg::CMD_TICK: begin
               // Both timers count milliseconds and stick at all ones.
               if (left_elapsed_ff != TIMER_MAX) begin
                  left_elapsed_in = left_elapsed_ff + 1'b1;
               end
               if (right_elapsed_ff != TIMER_MAX) begin
                  right_elapsed_in = right_elapsed_ff + 1'b1;
               end
            end
            dweh_pkg::CMD_LEFT: begin
               if (left_open) begin
                  left_step_now   = 1'b1;
                  left_elapsed_in = '0;
                  left_pos_in     = left_ahead_ff ? left_pos_ff + 1'b1 : left_pos_ff - 1'b1;
               end
            end
            dweh_pkg::CMD_RIGHT: begin
               if (right_open) begin
                  right_step_now   = 1'b1;
                  right_elapsed_in = '0;
                  right_pos_in     =
                     right_ahead_ff ? right_pos_ff + 1'b1 : right_pos_ff - 1'b1;
               end
            end
            dweh_pkg::CMD_SPEED: begin
               left_drive_in  = dweh_pkg::drive_of(req_ch.left_speed);
               right_drive_in = dweh_pkg::drive_of(req_ch.right_speed);
               // A zero speed keeps the remembered direction.
               if (req_ch.left_speed != '0) begin
                  left_ahead_in = !req_ch.left_speed[dweh_pkg::SPEED_WIDTH-1];
               end
               if (req_ch.right_speed != '0) begin
                  right_ahead_in = !req_ch.right_speed[dweh_pkg::SPEED_WIDTH-1];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_pos_ff      <= '0;
         right_pos_ff     <= '0;
         left_elapsed_ff  <= TIMER_MAX;
         right_elapsed_ff <= TIMER_MAX;
         left_ahead_ff    <= 1'b0;
         right_ahead_ff   <= 1'b0;
         left_drive_ff    <= '0;
         right_drive_ff   <= '0;
      end else begin
         left_pos_ff      <= left_pos_in;
         right_pos_ff     <= right_pos_in;
         left_elapsed_ff  <= left_elapsed_in;
         right_elapsed_ff <= right_elapsed_in;
         left_ahead_ff    <= left_ahead_in;
         right_ahead_ff   <= right_ahead_in;
         left_drive_ff    <= left_drive_in;
         right_drive_ff   <= right_drive_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: snapshot of the state as this request left it.
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type s1_base_ff, s1_base_in;
   logic [COUNT_WIDTH-1:0] s1_left_pos_ff, s1_right_pos_ff;

   always_comb begin
      s1_base_in.left_count  = dweh_pkg::RSP_COUNT_WIDTH'(left_pos_in);
      s1_base_in.right_count = dweh_pkg::RSP_COUNT_WIDTH'(right_pos_in);
      s1_base_in.left_drive  = left_drive_in;
      s1_base_in.right_drive = right_drive_in;
      s1_base_in.left_step   = left_step_now;
      s1_base_in.right_step  = right_step_now;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_base_ff      <= s1_base_in;
         s1_left_pos_ff  <= left_pos_in;
         s1_right_pos_ff <= right_pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: sign and magnitude of the wrapped count difference. Both
   // subtraction orders run side by side and the sign picks one.
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type s2_base_ff;
   logic                   s2_neg_ff, s2_neg_in;
   logic [COUNT_WIDTH-1:0] s2_mag_ff, s2_mag_in;
   logic [COUNT_WIDTH-1:0] diff_fwd, diff_back;

   assign diff_fwd  = s1_right_pos_ff - s1_left_pos_ff;
   assign diff_back = s1_left_pos_ff - s1_right_pos_ff;
   assign s2_neg_in = diff_fwd[COUNT_WIDTH-1];
   assign s2_mag_in = s2_neg_in ? diff_back : diff_fwd;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_base_ff <= s1_base_ff;
         s2_neg_ff  <= s2_neg_in;
         s2_mag_ff  <= s2_mag_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: two half-width products with the scale.
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type   s3_base_ff;
   logic                     s3_neg_ff;
   logic [PROD_LO_WIDTH-1:0] s3_prod_lo_ff, s3_prod_lo_in;
   logic [PROD_HI_WIDTH-1:0] s3_prod_hi_ff, s3_prod_hi_in;

   assign s3_prod_lo_in = PROD_LO_WIDTH'(s2_mag_ff[HALF_WIDTH-1:0]) * PROD_LO_WIDTH'(scale_ff);
   assign s3_prod_hi_in =
      PROD_HI_WIDTH'(s2_mag_ff[COUNT_WIDTH-1:HALF_WIDTH]) * PROD_HI_WIDTH'(scale_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_base_ff    <= s2_base_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_prod_lo_ff <= s3_prod_lo_in;
         s3_prod_hi_ff <= s3_prod_hi_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: full product plus one half, then drop the Q16 fraction.
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type s4_base_ff;
   logic                   s4_neg_ff;
   logic [Q_WIDTH-1:0]     s4_q_ff;
   logic [PROD_WIDTH-1:0]  prod_sum;

   assign prod_sum = (PROD_WIDTH'(s3_prod_hi_ff) << HALF_WIDTH) + PROD_WIDTH'(s3_prod_lo_ff)
                     + PROD_WIDTH'(dweh_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_base_ff <= s3_base_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_q_ff    <= prod_sum[PROD_WIDTH-1:dweh_pkg::FRAC_BITS];
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: since 256 is 1 modulo 255, the byte sum of q has the same
   // residue as q. The bytes are independent, so this is an adder tree.
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type   s5_base_ff;
   logic                     s5_neg_ff;
   logic                     s5_nonzero_ff;
   logic [SUM_WIDTH-1:0]     s5_sum_ff, s5_sum_in;
   logic [Q_BYTES*8-1:0]     q_padded;

   assign q_padded = (Q_BYTES * 8)'(s4_q_ff);

   always_comb begin
      s5_sum_in = '0;
      for (int b = 0; b < Q_BYTES; b++) begin
         s5_sum_in = s5_sum_in + SUM_WIDTH'(q_padded[b*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_base_ff    <= s4_base_ff;
         s5_neg_ff     <= s4_neg_ff;
         s5_nonzero_ff <= |s4_q_ff;
         s5_sum_ff     <= s5_sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register: one more byte fold, a single conditional subtract,
   // and the reflection for a negative difference (a negative difference
   // with a nonzero scaled value whose residue is zero reads as 255).
   // ------------------------------------------------------------------
   dweh_pkg::rsp_base_type              out_base_ff;
   logic [dweh_pkg::HEADING_WIDTH-1:0]  out_heading_ff, out_heading_in;
   logic [8:0]                          fold_sum;
   logic [dweh_pkg::HEADING_WIDTH-1:0]  residue;

   assign fold_sum = 9'(s5_sum_ff[SUM_WIDTH-1:8]) + 9'(s5_sum_ff[7:0]);
   assign residue  = (fold_sum >= 9'(dweh_pkg::FOLD_MODULUS))
                     ? 8'(fold_sum - 9'(dweh_pkg::FOLD_MODULUS)) : 8'(fold_sum);
   assign out_heading_in = (s5_neg_ff && s5_nonzero_ff)
                           ? dweh_pkg::FOLD_MODULUS - residue : residue;

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_base_ff    <= s5_base_ff;
         out_heading_ff <= out_heading_in;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.left_count    = out_base_ff.left_count;
   assign rsp_ch.right_count   = out_base_ff.right_count;
   assign rsp_ch.heading       = out_heading_ff;
   assign rsp_ch.left_duty     = out_base_ff.left_drive.duty;
   assign rsp_ch.left_reverse  = out_base_ff.left_drive.reverse;
   assign rsp_ch.right_duty    = out_base_ff.right_drive.duty;
   assign rsp_ch.right_reverse = out_base_ff.right_drive.reverse;
   assign rsp_ch.left_step     = out_base_ff.left_step;
   assign rsp_ch.right_step    = out_base_ff.right_step;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `DWEH_ASSERT_NOW(a_ready_when_drained, !out_v_ff, req_ch.ready,
      "request stalled with an empty output register")
   `DWEH_ASSERT_NEXT(a_left_edge_clears, left_step_now, left_elapsed_ff == '0,
      "accepted left edge did not clear its timer")
   `DWEH_ASSERT_NEXT(a_left_pos_held, !left_step_now, $stable(left_pos_ff),
      "left count moved without an accepted left edge")
   `DWEH_ASSERT_NEXT(a_right_pos_held, !right_step_now, $stable(right_pos_ff),
      "right count moved without an accepted right edge")
   `DWEH_ASSERT_NOW(a_steps_exclusive, out_v_ff,
      !(out_base_ff.left_step && out_base_ff.right_step),
      "one response carries steps on both wheels")

endmodule

`default_nettype wire
